// ===== src/frti_pkg.sv =====
// frti_pkg: opcodes and format constants for the round-to-integral unit
// no dependencies
package frti_pkg;

    localparam logic [1:0] OP_FLOOR = 2'd0;
    localparam logic [1:0] OP_CEIL  = 2'd1;
    localparam logic [1:0] OP_ROUND = 2'd2;

    localparam int WORD_W = 64;

    typedef struct packed {
        logic [1:0]  opcode;
        logic        is_double;
        logic [63:0] operand;
    } frti_in_t;

    typedef struct packed {
        logic [63:0] result;
    } frti_out_t;

endpackage

// ===== src/frti_if.sv =====
// frti_if: valid/ready channel carrying one word of type word_t
// depends on frti_pkg for the word types
interface frti_if #(parameter type word_t = frti_pkg::frti_in_t) (input logic clk);
    logic  valid;
    logic  ready;
    word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== src/frti_core.sv =====
// frti_core: combinational floor/ceil/round on a binary32 or binary64 pattern
// depends on frti_pkg
module frti_core (
    input  logic [1:0]  opcode,
    input  logic        is_double,
    input  logic [63:0] operand,
    output logic [63:0] result
);

    logic [63:0] bits;
    logic [10:0] e;
    logic [10:0] emax;
    logic [10:0] bias;
    logic [5:0]  mbits;
    logic        neg;
    logic [63:0] sign;
    logic [63:0] one;
    logic [63:0] fmask;
    logic [63:0] frac;
    logic [11:0] fbits_w;
    logic [5:0]  fbits;
    logic [63:0] ulp;
    logic [63:0] lowmask;
    logic [63:0] low;
    logic [63:0] trunc;
    logic        up;
    logic [63:0] res;

    always_comb
    begin
        if (is_double)
        begin
            bits  = operand;
            e     = operand[62:52];
            emax  = 11'h7ff;
            bias  = 11'd1023;
            mbits = 6'd52;
            neg   = operand[63];
            sign  = 64'h8000_0000_0000_0000;
        end
        else
        begin
            bits  = {32'd0, operand[31:0]};
            e     = {3'd0, operand[30:23]};
            emax  = 11'h0ff;
            bias  = 11'd127;
            mbits = 6'd23;
            neg   = operand[31];
            sign  = 64'h0000_0000_8000_0000;
        end
        fmask   = (64'd1 << mbits) - 64'd1;
        frac    = bits & fmask;
        one     = {53'd0, bias} << mbits;
        fbits_w = {1'b0, bias} + {6'd0, mbits} - {1'b0, e};
        fbits   = fbits_w[5:0];
        ulp     = 64'd1 << fbits;
        lowmask = ulp - 64'd1;
        low     = bits & lowmask;
        trunc   = bits & ~lowmask;
        unique case (opcode)
            frti_pkg::OP_FLOOR: up = neg;
            frti_pkg::OP_CEIL:  up = !neg;
            default:
                if (e < bias)
                    up = (e == bias - 11'd1);
                else
                    up = low >= (ulp >> 1);
        endcase

        if (e == emax || {1'b0, e} >= {1'b0, bias} + {6'd0, mbits})
            res = bits;
        else if (e == 11'd0 && frac == 64'd0)
            res = 64'd0;
        else if (e < bias)
            res = up ? (neg ? (sign | one) : one) : 64'd0;
        else if (low == 64'd0)
            res = bits;
        else
            res = up ? trunc + ulp : trunc;
        result = res;
    end

endmodule

// ===== src/float_round_to_integral.sv =====
// float_round_to_integral: registered floor/ceil/round-half-away unit
// depends on frti_pkg, frti_if and frti_core
//
//  channel | dir | word        | fields
//  in_ch   | in  | frti_in_t   | opcode, is_double, operand
//  out_ch  | out | frti_out_t  | result
//
// one word per cycle while out_ch is not stalled; stages are input register,
// rounding logic and result register, which drives the result and its valid flag
// reset clears only the two valid flags
// a stalled result holds; the input stage still advances into the result
// stage whenever that stage is empty or being taken
module float_round_to_integral (
    input logic     clk,
    input logic     rst_n,
    frti_if.sink    in_ch,
    frti_if.source  out_ch
);

    // input stage
    logic                 s1_valid_reg;
    logic                 s1_valid_next;
    frti_pkg::frti_in_t   s1_word_reg;
    // result stage
    logic                 s2_valid_reg;
    logic                 s2_valid_next;
    logic [63:0]          s2_result_reg;
    logic [63:0]          core_result;
    logic                 s2_load;
    logic                 s1_free;

    // result stage takes a new word when empty or draining this cycle
    assign s2_load = !s2_valid_reg || out_ch.ready;
    // input stage can take a word when it will hand its own on
    assign s1_free = !s1_valid_reg || s2_load;
    assign in_ch.ready = s1_free;

    assign s1_valid_next = in_ch.valid ? 1'b1 : (s1_valid_reg && !s2_load);
    assign s2_valid_next = s2_load ? s1_valid_reg : s2_valid_reg;

    frti_core u_core (
        .opcode    (s1_word_reg.opcode),
        .is_double (s1_word_reg.is_double),
        .operand   (s1_word_reg.operand),
        .result    (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_free)
                s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && s1_free)
            s1_word_reg <= in_ch.data;
        if (s2_load && s1_valid_reg)
            s2_result_reg <= core_result;
    end

    assign out_ch.valid       = s2_valid_reg;
    assign out_ch.data.result = s2_result_reg;

`ifndef SYNTH
    // a held result must not change while stalled
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
        else $error("result changed under stall");

    // an accepted word reaches the input stage
    a_s1: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ch.ready |=> s1_valid_reg)
        else $error("accepted word lost");

    // a word in the input stage moves on when the result stage is free
    a_move: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s2_load |=> s2_valid_reg)
        else $error("word dropped between stages");
`endif

endmodule

// ===== test/float_round_to_integral_tb.sv =====
// float_round_to_integral_tb: self-checking bench for the round-to-integral unit
// depends on frti_pkg, frti_if and float_round_to_integral
// directed floor/ceil/round corner values, then random words under several idling phases
module float_round_to_integral_tb;

    logic clk;
    logic rst_n;

    frti_if #(.word_t(frti_pkg::frti_in_t))  in_ch  (.clk(clk));
    frti_if #(.word_t(frti_pkg::frti_out_t)) out_ch (.clk(clk));

    float_round_to_integral u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    // expected rounded values, oldest first
    logic [63:0] rounded_q[$];
    int          n_errors;
    int          idle_cycles;
    int          send_idle_pct;
    int          recv_stall_pct;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // exact round of one format; sign sits just above the exponent
    function automatic logic [63:0] round_fmt(logic [63:0] bits, int ebits, int mbits,
                                              logic [1:0] op);
        logic [63:0] emax;
        logic [63:0] bias;
        logic [63:0] expo;
        logic [63:0] frac;
        logic [63:0] one_v;
        logic [63:0] sgn;
        logic [63:0] ulp;
        logic [63:0] low;
        logic [63:0] trunc;
        logic        neg;
        logic        up;
        emax  = (64'd1 << ebits) - 64'd1;
        bias  = emax >> 1;
        neg   = bits[ebits + mbits];
        expo  = (bits >> mbits) & emax;
        frac  = bits & ((64'd1 << mbits) - 64'd1);
        one_v = bias << mbits;
        sgn   = 64'd1 << (ebits + mbits);
        if (expo == emax || expo >= bias + mbits)
            return bits;
        if (expo == 0 && frac == 0)
            return 64'd0;
        if (expo < bias)
        begin
            // magnitude strictly between zero and one
            if (op == frti_pkg::OP_FLOOR)
                up = neg;
            else if (op == frti_pkg::OP_CEIL)
                up = ~neg;
            else
                up = (expo == bias - 64'd1);
            if (!up)
                return 64'd0;
            return neg ? (sgn | one_v) : one_v;
        end
        ulp   = 64'd1 << (bias + mbits - expo);
        low   = bits & (ulp - 64'd1);
        trunc = bits & ~(ulp - 64'd1);
        if (low == 0)
            return bits;
        if (op == frti_pkg::OP_FLOOR)
            up = neg;
        else if (op == frti_pkg::OP_CEIL)
            up = ~neg;
        else
            up = (low >= (ulp >> 1));
        return up ? trunc + ulp : trunc;
    endfunction

    function automatic logic [63:0] predict_rounded(frti_pkg::frti_in_t w);
        logic [63:0] r;
        if (w.is_double)
            return round_fmt(w.operand, 11, 52, w.opcode);
        r = round_fmt({32'd0, w.operand[31:0]}, 8, 23, w.opcode);
        return {32'd0, r[31:0]};
    endfunction

    // send one word; valid stays high between back-to-back words
    task automatic send_word(logic [1:0] op, logic dbl, logic [63:0] v);
        frti_pkg::frti_in_t w;
        w.opcode    = op;
        w.is_double = dbl;
        w.operand   = v;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= w;
        rounded_q.push_back(predict_rounded(w));
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
    endtask

    task automatic stop_sending();
        in_ch.valid <= 1'b0;
        in_ch.data  <= '0;
    endtask

    // random single value, biased toward the fractional exponent range
    function automatic logic [63:0] rand_single();
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(3))
            0, 1: v[30:23] = 8'($urandom_range(110, 152));
            2:    v[30:23] = 8'($urandom_range(125, 129));
            default: ;
        endcase
        return {$urandom, v};
    endfunction

    function automatic logic [63:0] rand_double();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(3))
            0, 1: v[62:52] = 11'($urandom_range(1000, 1080));
            2:    v[62:52] = 11'($urandom_range(1021, 1025));
            default: ;
        endcase
        return v;
    endfunction

    // halves, exact ties, negative zero, nan, inf, subnormals, large magnitudes
    task automatic test_corner_values();
        logic [1:0] op;
        for (int k = 0; k < 4; k++)
        begin
            op = k[1:0];
            send_word(op, 1'b0, 64'h0000_0000_3F00_0000);  // 0.5
            send_word(op, 1'b0, 64'hFFFF_FFFF_BFC0_0000);  // -1.5, junk upper bits
            send_word(op, 1'b0, 64'h0000_0000_8000_0000);  // -0
            send_word(op, 1'b0, 64'h0000_0000_7FC0_1234);  // nan
            send_word(op, 1'b1, 64'hFFF0_0000_0000_0000);  // -inf
            send_word(op, 1'b1, 64'h8000_0000_0000_0001);  // negative subnormal
        end
        send_word(frti_pkg::OP_ROUND, 1'b0, 64'h0000_0000_4B00_0000);  // 2^23
        send_word(frti_pkg::OP_CEIL,  1'b1, 64'hC32F_FFFF_FFFF_FFFF);  // just under -2^52
        send_word(frti_pkg::OP_ROUND, 1'b1, 64'h3FE0_0000_0000_0000);  // 0.5 double
        send_word(frti_pkg::OP_ROUND, 1'b1, 64'h3FDF_FFFF_FFFF_FFFF);  // just under 0.5
        send_word(frti_pkg::OP_FLOOR, 1'b0, 64'h0000_0000_4040_0000);  // integral 3.0
        stop_sending();
    endtask

    task automatic test_random_words(int count);
        logic dbl;
        for (int k = 0; k < count; k++)
        begin
            dbl = 1'($urandom_range(1));
            send_word(2'($urandom_range(3)), dbl, dbl ? rand_double() : rand_single());
        end
        stop_sending();
    endtask

    task automatic wait_drained();
        while (rounded_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // receiver: random stalls, compare each result with the oldest prediction
    initial
    begin
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready)
            begin
                if (rounded_q.size() == 0)
                begin
                    $display("%0t: unexpected result: expected none, actual %h",
                             $time, out_ch.data.result);
                    n_errors++;
                end
                else if (out_ch.data.result !== rounded_q[0])
                begin
                    $display("%0t: result mismatch: expected %h, actual %h",
                             $time, rounded_q[0], out_ch.data.result);
                    n_errors++;
                    void'(rounded_q.pop_front());
                end
                else
                    void'(rounded_q.pop_front());
            end
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog: cycles without any accepted word on either channel
    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles = 0;
            else if (++idle_cycles >= 20000)
            begin
                $display("float_round_to_integral_tb NOT OK");
                $finish;
            end
        end
    end

    initial
    begin
        n_errors       = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        rst_n          = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.data     = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_corner_values();
        wait_drained();
        // idling phases: none, sender, receiver, both
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct  = (ph == 1) ? 49 : (ph == 3) ? 16 : 0;
            recv_stall_pct = (ph == 2) ? 49 : (ph == 3) ? 16 : 0;
            test_random_words(250);
            wait_drained();
        end

        if (n_errors == 0)
            $display("float_round_to_integral_tb OK");
        else
            $display("float_round_to_integral_tb NOT OK");
        $finish;
    end
endmodule
